### src/lpxr_pkg.sv
// ----------------------------------------------------------------------------
// LCM prime exponent ranker package
// Widths, limits, the prime table and its reciprocals, and the ranker's
// sequencer state type; the checker uses the LCM limit.
// ----------------------------------------------------------------------------
package lpxr_pkg;

    localparam int C_VALUE_W   = 7;
    localparam int C_EXP_W     = 3;
    localparam int C_LCM_W     = 27;
    localparam int C_REC_W     = 16;
    localparam int C_REC_SHIFT = 16;
    localparam int C_MUL_W     = C_LCM_W + C_REC_W;
    localparam int C_TAB_DEPTH = 31;
    localparam int C_TAB_IW    = 5;
    localparam int C_MAX_VALUE = 100;

    localparam logic [C_LCM_W-1:0] C_LCM_LIMIT = 27'd100000000;
    localparam logic [C_EXP_W-1:0] C_EXP_MAX   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FACT,
        ST_LCM,
        ST_RANK
    } t_state;

    // Primes that can divide a seven-bit value; larger primes never divide.
    function automatic logic [C_VALUE_W-1:0] prime_at(input logic [C_TAB_IW-1:0] idx);
        logic [C_VALUE_W-1:0] p;
        case (idx)
            5'd0:    p = 7'd2;
            5'd1:    p = 7'd3;
            5'd2:    p = 7'd5;
            5'd3:    p = 7'd7;
            5'd4:    p = 7'd11;
            5'd5:    p = 7'd13;
            5'd6:    p = 7'd17;
            5'd7:    p = 7'd19;
            5'd8:    p = 7'd23;
            5'd9:    p = 7'd29;
            5'd10:   p = 7'd31;
            5'd11:   p = 7'd37;
            5'd12:   p = 7'd41;
            5'd13:   p = 7'd43;
            5'd14:   p = 7'd47;
            5'd15:   p = 7'd53;
            5'd16:   p = 7'd59;
            5'd17:   p = 7'd61;
            5'd18:   p = 7'd67;
            5'd19:   p = 7'd71;
            5'd20:   p = 7'd73;
            5'd21:   p = 7'd79;
            5'd22:   p = 7'd83;
            5'd23:   p = 7'd89;
            5'd24:   p = 7'd97;
            5'd25:   p = 7'd101;
            5'd26:   p = 7'd103;
            5'd27:   p = 7'd107;
            5'd28:   p = 7'd109;
            5'd29:   p = 7'd113;
            5'd30:   p = 7'd127;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Rounded-up reciprocals 2^16 / p for the multiply-based divisibility test.
    function automatic logic [C_REC_W-1:0] recip_at(input logic [C_TAB_IW-1:0] idx);
        logic [C_REC_W-1:0] r;
        case (idx)
            5'd0:    r = 16'd32768;
            5'd1:    r = 16'd21846;
            5'd2:    r = 16'd13108;
            5'd3:    r = 16'd9363;
            5'd4:    r = 16'd5958;
            5'd5:    r = 16'd5042;
            5'd6:    r = 16'd3856;
            5'd7:    r = 16'd3450;
            5'd8:    r = 16'd2850;
            5'd9:    r = 16'd2260;
            5'd10:   r = 16'd2115;
            5'd11:   r = 16'd1772;
            5'd12:   r = 16'd1599;
            5'd13:   r = 16'd1525;
            5'd14:   r = 16'd1395;
            5'd15:   r = 16'd1237;
            5'd16:   r = 16'd1111;
            5'd17:   r = 16'd1075;
            5'd18:   r = 16'd979;
            5'd19:   r = 16'd924;
            5'd20:   r = 16'd898;
            5'd21:   r = 16'd830;
            5'd22:   r = 16'd790;
            5'd23:   r = 16'd737;
            5'd24:   r = 16'd676;
            5'd25:   r = 16'd649;
            5'd26:   r = 16'd637;
            5'd27:   r = 16'd613;
            5'd28:   r = 16'd602;
            5'd29:   r = 16'd580;
            5'd30:   r = 16'd517;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### src/lcm_prime_exponent_ranker_unit.sv
// ----------------------------------------------------------------------------
// LCM prime exponent ranker
// Factors each word by trial division over the prime table, keeps the largest
// exponent per prime, and after the last word of a set emits the ranked
// factors of the least common multiple with the saturated LCM.
// ----------------------------------------------------------------------------
// Factoring tries the primes in table order and divides out each factor
// found, stopping once the value is 1 or the last prime has been tried. A
// set-closing word then multiplies each prime into the LCM as often as its
// exponent; a scan by exponent level then emits the ranked results. The
// divisibility test and the LCM product share one multiplier. Synchronous
// active-low reset clears sequencer, output valid and exponent table at once.
module lcm_prime_exponent_ranker_unit #(
    parameter int NUM_PRIMES = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [6:0]  i_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [26:0] o_lcm,
    output logic        o_overflow,
    output logic [6:0]  o_prime,
    output logic [2:0]  o_exponent,
    output logic        o_last_res
);

    localparam int NP = (NUM_PRIMES < lpxr_pkg::C_TAB_DEPTH) ?
                        NUM_PRIMES : lpxr_pkg::C_TAB_DEPTH;
    localparam int IW = (NP > 1) ? $clog2(NP) : 1;
    localparam int CW = $clog2(NP + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(NP - 1);

    lpxr_pkg::t_state r_state, n_state;

    logic [lpxr_pkg::C_EXP_W-1:0]   r_mexp [NP];
    logic [lpxr_pkg::C_VALUE_W-1:0] r_v, n_v;
    logic                           r_last, n_last;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [lpxr_pkg::C_EXP_W-1:0]   r_e, n_e;
    logic [lpxr_pkg::C_EXP_W-1:0]   r_kcnt, n_kcnt;
    logic [lpxr_pkg::C_LCM_W-1:0]   r_lcm, n_lcm;
    logic                           r_ovf, n_ovf;
    logic [CW-1:0]                  r_nz, n_nz;
    logic [CW-1:0]                  r_sent, n_sent;
    logic [lpxr_pkg::C_EXP_W-1:0]   r_top, n_top;
    logic [lpxr_pkg::C_EXP_W-1:0]   r_lvl, n_lvl;

    logic                           r_ovalid, n_ovalid;
    logic [lpxr_pkg::C_LCM_W-1:0]   r_olcm, n_olcm;
    logic                           r_oovf, n_oovf;
    logic [lpxr_pkg::C_VALUE_W-1:0] r_oprime, n_oprime;
    logic [lpxr_pkg::C_EXP_W-1:0]   r_oexp, n_oexp;
    logic                           r_olast, n_olast;

    logic [lpxr_pkg::C_EXP_W-1:0]   cur_exp;
    logic [lpxr_pkg::C_VALUE_W-1:0] prime_cur;
    logic [lpxr_pkg::C_REC_W-1:0]   recip_cur;
    logic [lpxr_pkg::C_LCM_W-1:0]   mul_a;
    logic [lpxr_pkg::C_REC_W-1:0]   mul_b;
    logic [lpxr_pkg::C_MUL_W-1:0]   mul_p;
    logic                           fact_div;
    logic                           fact_done;
    logic                           lcm_over;
    logic                           lcm_mul;
    logic                           can_load;
    logic                           rank_hit;
    logic                           rank_last;
    logic                           rank_fin;
    logic                           tbl_we;

    assign cur_exp   = r_mexp[r_idx];
    assign prime_cur = lpxr_pkg::prime_at(lpxr_pkg::C_TAB_IW'(r_idx));
    assign recip_cur = lpxr_pkg::recip_at(lpxr_pkg::C_TAB_IW'(r_idx));

    // The shared multiplier tests divisibility while factoring and grows the
    // LCM afterwards.
    always_comb begin
        if (r_state == lpxr_pkg::ST_FACT) begin
            mul_a = lpxr_pkg::C_LCM_W'(r_v);
            mul_b = recip_cur;
        end else begin
            mul_a = r_lcm;
            mul_b = lpxr_pkg::C_REC_W'(prime_cur);
        end
    end

    assign mul_p = lpxr_pkg::C_MUL_W'(mul_a) * lpxr_pkg::C_MUL_W'(mul_b);

    assign fact_div  = mul_p[lpxr_pkg::C_REC_SHIFT-1:0] < recip_cur;
    assign fact_done = !fact_div && ((r_v == 7'd1) || (r_idx == IDX_LAST));
    assign lcm_over  = mul_p > lpxr_pkg::C_MUL_W'(lpxr_pkg::C_LCM_LIMIT);
    assign lcm_mul   = r_kcnt != cur_exp;
    assign can_load  = !r_ovalid || i_out_ready;
    assign rank_hit  = cur_exp == r_lvl;
    assign rank_last = (r_sent + CW'(1)) == r_nz;
    assign rank_fin  = (r_state == lpxr_pkg::ST_RANK) && can_load &&
                       ((r_nz == '0) || (rank_hit && rank_last));
    assign tbl_we    = (r_state == lpxr_pkg::ST_FACT) && !fact_div && (r_e > cur_exp);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpxr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lpxr_pkg::ST_FACT;
                end
            end
            lpxr_pkg::ST_FACT: begin
                if (fact_done) begin
                    n_state = r_last ? lpxr_pkg::ST_LCM : lpxr_pkg::ST_IDLE;
                end
            end
            lpxr_pkg::ST_LCM: begin
                if (!lcm_mul && (r_idx == IDX_LAST)) begin
                    n_state = lpxr_pkg::ST_RANK;
                end
            end
            lpxr_pkg::ST_RANK: begin
                if (rank_fin) begin
                    n_state = lpxr_pkg::ST_IDLE;
                end
            end
            default: n_state = lpxr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == lpxr_pkg::ST_IDLE);
        o_out_valid = r_ovalid;
        o_lcm       = r_olcm;
        o_overflow  = r_oovf;
        o_prime     = r_oprime;
        o_exponent  = r_oexp;
        o_last_res  = r_olast;
    end

    always_comb begin
        n_v      = r_v;
        n_last   = r_last;
        n_idx    = r_idx;
        n_e      = r_e;
        n_kcnt   = r_kcnt;
        n_lcm    = r_lcm;
        n_ovf    = r_ovf;
        n_nz     = r_nz;
        n_sent   = r_sent;
        n_top    = r_top;
        n_lvl    = r_lvl;
        n_ovalid = r_ovalid && !i_out_ready;
        n_olcm   = r_olcm;
        n_oovf   = r_oovf;
        n_oprime = r_oprime;
        n_oexp   = r_oexp;
        n_olast  = r_olast;
        case (r_state)
            lpxr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if ((i_value == '0) || (int'(i_value) > lpxr_pkg::C_MAX_VALUE)) begin
                        n_v = 7'd1;
                    end else begin
                        n_v = i_value;
                    end
                    n_last = i_last;
                    n_idx  = '0;
                    n_e    = '0;
                end
            end
            lpxr_pkg::ST_FACT: begin
                if (fact_div) begin
                    n_v = mul_p[lpxr_pkg::C_REC_SHIFT +: lpxr_pkg::C_VALUE_W];
                    if (r_e != lpxr_pkg::C_EXP_MAX) begin
                        n_e = r_e + 3'd1;
                    end
                end else begin
                    n_e = '0;
                    if (fact_done) begin
                        n_idx  = '0;
                        n_kcnt = '0;
                        n_lcm  = 27'd1;
                        n_ovf  = 1'b0;
                        n_nz   = '0;
                        n_top  = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            lpxr_pkg::ST_LCM: begin
                if (lcm_mul) begin
                    n_lcm  = lcm_over ? lpxr_pkg::C_LCM_LIMIT :
                                        mul_p[lpxr_pkg::C_LCM_W-1:0];
                    n_ovf  = r_ovf || lcm_over;
                    n_kcnt = r_kcnt + 3'd1;
                end else begin
                    n_kcnt = '0;
                    if (cur_exp != '0) begin
                        n_nz = r_nz + CW'(1);
                        if (cur_exp > r_top) begin
                            n_top = cur_exp;
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_lvl  = n_top;
                        n_sent = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            lpxr_pkg::ST_RANK: begin
                if (can_load) begin
                    if (r_nz == '0) begin
                        n_ovalid = 1'b1;
                        n_olcm   = r_lcm;
                        n_oovf   = r_ovf;
                        n_oprime = '0;
                        n_oexp   = '0;
                        n_olast  = 1'b1;
                    end else begin
                        if (rank_hit) begin
                            n_ovalid = 1'b1;
                            n_olcm   = r_lcm;
                            n_oovf   = r_ovf;
                            n_oprime = prime_cur;
                            n_oexp   = r_lvl;
                            n_olast  = rank_last;
                            n_sent   = r_sent + CW'(1);
                        end
                        if (r_idx == '0) begin
                            n_idx = IDX_LAST;
                            n_lvl = r_lvl - 3'd1;
                        end else begin
                            n_idx = r_idx - IW'(1);
                        end
                    end
                end
            end
            default: begin
                n_e = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lpxr_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
            r_idx    <= '0;
            r_e      <= '0;
            r_kcnt   <= '0;
            r_nz     <= '0;
            r_sent   <= '0;
            r_top    <= '0;
            r_lvl    <= '0;
            for (int i = 0; i < NP; i++) begin
                r_mexp[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
            r_idx    <= n_idx;
            r_e      <= n_e;
            r_kcnt   <= n_kcnt;
            r_nz     <= n_nz;
            r_sent   <= n_sent;
            r_top    <= n_top;
            r_lvl    <= n_lvl;
            if (rank_fin) begin
                for (int i = 0; i < NP; i++) begin
                    r_mexp[i] <= '0;
                end
            end else if (tbl_we) begin
                r_mexp[r_idx] <= r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_lcm    <= n_lcm;
        r_ovf    <= n_ovf;
        r_olcm   <= n_olcm;
        r_oovf   <= n_oovf;
        r_oprime <= n_oprime;
        r_oexp   <= n_oexp;
        r_olast  <= n_olast;
    end

endmodule

### src/lpxr_checker.sv
// ----------------------------------------------------------------------------
// LCM prime exponent ranker checker
// Port-level assertions on the ranker's channels, bound to every ranker instance.
// ----------------------------------------------------------------------------
module lpxr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [26:0] o_lcm,
    input logic        o_overflow,
    input logic [6:0]  o_prime,
    input logic [2:0]  o_exponent,
    input logic        o_last_res
);

    logic       r_open;
    logic [2:0] r_prev_exp;

    // Tracks whether a set is open and the exponent of the previous word delivered within it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_prev_exp <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_open     <= !o_last_res;
            r_prev_exp <= o_exponent;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_prime) &&
            $stable(o_exponent) && $stable(o_lcm))
        else $error("Output word dropped or changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted on consecutive cycles.");

    a_unit_lcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_prime == 7'd0) |->
            (o_exponent == 3'd0) && o_last_res && (o_lcm == 27'd1) && !o_overflow)
        else $error("Malformed result for an LCM of one.");

    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_open |-> (o_exponent <= r_prev_exp) && (o_exponent != 3'd0))
        else $error("Exponents out of descending order within a set.");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_lcm == lpxr_pkg::C_LCM_LIMIT)
        else $error("Overflow flagged without a saturated LCM.");

endmodule

bind lcm_prime_exponent_ranker_unit lpxr_checker u_lpxr_checker (.*);
